FILE: hdl/vgm_pkg.sv
// Shared types, codes and face rules for the voxel greedy mesher.
// Used by vgm_front, vgm_job_fifo, vgm_back and voxel_greedy_mesher_unit.
package vgm_pkg;

	localparam logic [2:0] BLK_NULL  = 3'd0;
	localparam logic [2:0] BLK_AIR   = 3'd1;
	localparam logic [2:0] BLK_STONE = 3'd2;
	localparam logic [2:0] BLK_DIRT  = 3'd3;
	localparam logic [2:0] BLK_GRASS = 3'd4;
	localparam logic [2:0] BLK_SAND  = 3'd5;
	localparam logic [2:0] BLK_WATER = 3'd6;

	localparam logic [1:0] NRM_NONE  = 2'd0;
	localparam logic [1:0] NRM_PLUS  = 2'd1;
	localparam logic [1:0] NRM_MINUS = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SLICE = 1'b1;

	localparam logic [7:0] TEX_NONE       = 8'd255;
	localparam logic [7:0] TEX_STONE      = 8'd3;
	localparam logic [7:0] TEX_DIRT       = 8'd2;
	localparam logic [7:0] TEX_GRASS_TOP  = 8'd0;
	localparam logic [7:0] TEX_GRASS_SIDE = 8'd1;
	localparam logic [7:0] TEX_GRASS_BOT  = 8'd2;
	localparam logic [7:0] TEX_SAND       = 8'd4;

	typedef struct packed {
		logic              opcode;
		logic [2:0]        vx;
		logic [2:0]        vy;
		logic [2:0]        vz;
		logic [2:0]        block_code;
		logic [1:0]        slice_axis;
		logic signed [3:0] slice_index;
	} cmd_t;

	typedef struct packed {
		logic       has_quad;
		logic       last;
		logic [1:0] face_axis;
		logic       facing_negative;
		logic [3:0] pos_x;
		logic [3:0] pos_y;
		logic [3:0] pos_z;
		logic [3:0] span_first;
		logic [3:0] span_second;
		logic [2:0] face_block;
		logic [7:0] texture_index;
	} quad_t;

	typedef enum logic [1:0] {
		JOB_WRITE,
		JOB_SLICE,
		JOB_EMPTY
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [8:0] vaddr;
		logic [2:0] blk;
		logic [1:0] axis;
		logic [2:0] s_lo;
		logic [3:0] s_next;
		logic       p_oob;
		logic       q_oob;
		logic [3:0] len1;
		logic [3:0] len2;
	} job_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_BUILD,
		ST_DRAIN,
		ST_SCAN_RD,
		ST_SCAN_CK,
		ST_WID_RD,
		ST_WID_CK,
		ST_HGT_RD,
		ST_HGT_CK,
		ST_PUSH,
		ST_FIN
	} back_state_t;

	function automatic logic is_opaque(input logic [2:0] b);
		return !(b == BLK_NULL || b == BLK_AIR || b == BLK_WATER);
	endfunction

	function automatic logic [4:0] mark_of(input logic [2:0] cur, input logic [2:0] cmp);
		logic co;
		logic po;
		logic [4:0] r;
		co = is_opaque(cur);
		po = is_opaque(cmp);
		r = 5'd0;
		if (co == po) begin
			if (cur == BLK_WATER && cmp != BLK_WATER && !po)
				r = {NRM_PLUS, BLK_WATER};
			else if (cmp == BLK_WATER && cur != BLK_WATER && !co)
				r = {NRM_MINUS, BLK_WATER};
		end else if (co) begin
			r = {NRM_PLUS, cur};
		end else begin
			r = {NRM_MINUS, cmp};
		end
		return r;
	endfunction

	function automatic logic [7:0] texture_of(input logic [2:0] b, input logic [1:0] axis,
			input logic [1:0] nrm);
		logic [7:0] t;
		case (b)
			BLK_STONE: t = TEX_STONE;
			BLK_DIRT:  t = TEX_DIRT;
			BLK_GRASS: begin
				if (axis == AXIS_Z && nrm == NRM_PLUS)
					t = TEX_GRASS_TOP;
				else if (axis == AXIS_Z && nrm == NRM_MINUS)
					t = TEX_GRASS_BOT;
				else
					t = TEX_GRASS_SIDE;
			end
			BLK_SAND:  t = TEX_SAND;
			default:   t = TEX_NONE;
		endcase
		return t;
	endfunction

endpackage

FILE: hdl/voxel_greedy_mesher_unit.sv
// Top level of the voxel greedy mesher: front end, job queue, back end.
// Depends on vgm_pkg, vgm_front, vgm_job_fifo and vgm_back.
//
//   channel  payload  handshake              transfer at
//   cmd      cmd_t    cmd_valid / cmd_stall   cmd_valid && !cmd_stall
//   quad     quad_t   quad_valid / quad_stall quad_valid && !quad_stall
//
// After reset a clearing pass nulls all 512 voxel store entries; cmd_stall is high meanwhile.
// The back end does a voxel write as it pops the job; an invalid slice gives one empty result.
// A slice builds the face mask through the voxel store's two read ports, then reads each
// mask probe and checks it in the merge scan (one mask read port), and pushes each quad.
// The two-entry queue and the output register let either side stall on its own.
module voxel_greedy_mesher_unit import vgm_pkg::*; #(
	parameter int SIZE_X = 8,
	parameter int SIZE_Y = 8,
	parameter int SIZE_Z = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  logic  cmd_valid,
	output logic  cmd_stall,
	output quad_t quad,
	output logic  quad_valid,
	input  logic  quad_stall
);

	logic push, q_full, pop, head_valid, clearing;
	job_t push_job, head;

	vgm_front #(
		.SIZE_X(SIZE_X),
		.SIZE_Y(SIZE_Y),
		.SIZE_Z(SIZE_Z)
	) u_front (
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.q_full(q_full),
		.clearing(clearing),
		.push(push),
		.job(push_job)
	);

	vgm_job_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	vgm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(head_valid),
		.job(head),
		.pop(pop),
		.clearing(clearing),
		.quad(quad),
		.quad_valid(quad_valid),
		.quad_stall(quad_stall)
	);

endmodule

FILE: hdl/vgm_front.sv
// Front end: accepts commands, checks ranges and turns them into jobs; drops writes outside the chunk.
// Depends on vgm_pkg.
module vgm_front import vgm_pkg::*; #(
	parameter int SIZE_X = 8,
	parameter int SIZE_Y = 8,
	parameter int SIZE_Z = 8
) (
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  logic q_full,
	input  logic clearing,
	output logic push,
	output job_t job
);

	localparam logic [3:0] LEN_X = 4'(SIZE_X);
	localparam logic [3:0] LEN_Y = 4'(SIZE_Y);
	localparam logic [3:0] LEN_Z = 4'(SIZE_Z);

	logic [3:0] axis_len;
	logic [3:0] si_u;
	logic [3:0] s_next;
	logic       axis_ok;
	logic       s_ok;
	logic       in_chunk;

	assign cmd_stall = q_full || clearing;

	always_comb begin
		si_u = cmd.slice_index;
		s_next = si_u + 4'd1;
		axis_ok = cmd.slice_axis == AXIS_X || cmd.slice_axis == AXIS_Y ||
			cmd.slice_axis == AXIS_Z;
		case (cmd.slice_axis)
			AXIS_X:  axis_len = LEN_X;
			AXIS_Y:  axis_len = LEN_Y;
			default: axis_len = LEN_Z;
		endcase
		if (si_u[3])
			s_ok = (cmd.slice_index == -4'sd1);
		else
			s_ok = {1'b0, si_u[2:0]} < axis_len;
		in_chunk = {1'b0, cmd.vx} < LEN_X && {1'b0, cmd.vy} < LEN_Y &&
			{1'b0, cmd.vz} < LEN_Z;

		job.vaddr = {cmd.vx, cmd.vy, cmd.vz};
		job.blk = cmd.block_code;
		job.axis = cmd.slice_axis;
		job.s_lo = si_u[2:0];
		job.s_next = s_next;
		job.p_oob = (cmd.slice_index == -4'sd1);
		job.q_oob = (s_next == axis_len);
		case (cmd.slice_axis)
			AXIS_X: begin
				job.len1 = LEN_Y;
				job.len2 = LEN_Z;
			end
			AXIS_Y: begin
				job.len1 = LEN_Z;
				job.len2 = LEN_X;
			end
			default: begin
				job.len1 = LEN_X;
				job.len2 = LEN_Y;
			end
		endcase
		if (cmd.opcode == OP_WRITE)
			job.kind = JOB_WRITE;
		else if (axis_ok && s_ok)
			job.kind = JOB_SLICE;
		else
			job.kind = JOB_EMPTY;

		push = cmd_valid && !cmd_stall && !(cmd.opcode == OP_WRITE && !in_chunk);
	end

endmodule

FILE: hdl/vgm_job_fifo.sv
// Two-entry job queue between front end and back end.
// Depends on vgm_pkg.
module vgm_job_fifo import vgm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head
);

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_job;
	end

endmodule

FILE: hdl/vgm_back.sv
// Back end: voxel store, face mask build, greedy rectangle merge, quad output.
// Depends on vgm_pkg.
module vgm_back import vgm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  job_valid,
	input  job_t  job,
	output logic  pop,
	output logic  clearing,
	output quad_t quad,
	output logic  quad_valid,
	input  logic  quad_stall
);

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [8:0]  clr_q;
	logic [2:0]  bi_q, bi_d, bj_q, bj_d;
	logic [3:0]  ci_q, ci_d, cj_q, cj_d, w_q, w_d, h_q, h_d, k_q, k_d;
	logic [4:0]  m_q, m_d;
	logic [63:0] used_q, rect;
	logic        hold_valid_q, out_valid_q;
	quad_t       hold_q, out_q, new_quad, empty_quad, last_quad;

	logic [2:0]  vox_mem [512];
	logic [2:0]  vox_p_q, vox_q_q;
	logic [4:0]  mask_mem [64];
	logic [4:0]  rd_q, eff;
	logic [5:0]  rd_addr, rd_addr_q;
	logic        valid_s1;
	logic [5:0]  midx_s1;

	logic        vox_we;
	logic [8:0]  vox_waddr, p_addr, q_addr;
	logic [2:0]  vox_wdata, oob_blk, pblk, qblk;
	logic        out_free, push_go, fin_go, load_out;
	logic [3:0]  ci_1, cj_1, ci_w, cj_h, ci_k, cw_1, cjh_1, k_1;

	function automatic logic [8:0] vox_addr(input logic [1:0] axis, input logic [2:0] m,
			input logic [2:0] i, input logic [2:0] j);
		logic [8:0] a;
		case (axis)
			AXIS_X:  a = {m, i, j};
			AXIS_Y:  a = {j, m, i};
			default: a = {i, j, m};
		endcase
		return a;
	endfunction

	assign eff = used_q[rd_addr_q] ? 5'd0 : rd_q;
	assign out_free = !out_valid_q || !quad_stall;
	assign ci_1 = ci_q + 4'd1;
	assign cj_1 = cj_q + 4'd1;
	assign ci_w = ci_q + w_q;
	assign cj_h = cj_q + h_q;
	assign ci_k = ci_q + k_q;
	assign cw_1 = ci_w + 4'd1;
	assign cjh_1 = cj_h + 4'd1;
	assign k_1 = k_q + 4'd1;

	always_comb begin
		state_d = state_q;
		bi_d = bi_q;
		bj_d = bj_q;
		ci_d = ci_q;
		cj_d = cj_q;
		w_d = w_q;
		h_d = h_q;
		k_d = k_q;
		m_d = m_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == 9'h1FF)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (job_valid) begin
					case (job.kind)
						JOB_SLICE: begin
							state_d = ST_BUILD;
							bi_d = 3'd0;
							bj_d = 3'd0;
						end
						JOB_EMPTY: state_d = ST_FIN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_BUILD: begin
				if ({1'b0, bi_q} + 4'd1 == job_q.len1) begin
					bi_d = 3'd0;
					if ({1'b0, bj_q} + 4'd1 == job_q.len2)
						state_d = ST_DRAIN;
					else
						bj_d = bj_q + 3'd1;
				end else begin
					bi_d = bi_q + 3'd1;
				end
			end
			ST_DRAIN: begin
				ci_d = 4'd0;
				cj_d = 4'd0;
				state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CK;
			ST_SCAN_CK: begin
				if (eff[4:3] == NRM_NONE) begin
					state_d = ST_SCAN_RD;
					if (ci_1 == job_q.len1) begin
						if (cj_1 == job_q.len2) begin
							state_d = ST_FIN;
						end else begin
							ci_d = 4'd0;
							cj_d = cj_1;
						end
					end else begin
						ci_d = ci_1;
					end
				end else begin
					m_d = eff;
					w_d = 4'd1;
					h_d = 4'd1;
					k_d = 4'd0;
					if (ci_1 < job_q.len1)
						state_d = ST_WID_RD;
					else if (cj_1 < job_q.len2)
						state_d = ST_HGT_RD;
					else
						state_d = ST_PUSH;
				end
			end
			ST_WID_RD: state_d = ST_WID_CK;
			ST_WID_CK: begin
				if (eff == m_q && cw_1 < job_q.len1) begin
					w_d = w_q + 4'd1;
					state_d = ST_WID_RD;
				end else begin
					if (eff == m_q)
						w_d = w_q + 4'd1;
					if (cj_1 < job_q.len2)
						state_d = ST_HGT_RD;
					else
						state_d = ST_PUSH;
				end
			end
			ST_HGT_RD: state_d = ST_HGT_CK;
			ST_HGT_CK: begin
				if (eff != m_q) begin
					state_d = ST_PUSH;
				end else if (k_1 < w_q) begin
					k_d = k_1;
					state_d = ST_HGT_RD;
				end else begin
					h_d = h_q + 4'd1;
					k_d = 4'd0;
					if (cjh_1 < job_q.len2)
						state_d = ST_HGT_RD;
					else
						state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!hold_valid_q || out_free) begin
					state_d = ST_SCAN_RD;
					if (ci_w == job_q.len1) begin
						if (cj_1 == job_q.len2) begin
							state_d = ST_FIN;
						end else begin
							ci_d = 4'd0;
							cj_d = cj_1;
						end
					end else begin
						ci_d = ci_w;
					end
				end
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		logic [3:0] col;
		logic [3:0] row;
		pop = (state_q == ST_IDLE) && job_valid;
		clearing = (state_q == ST_CLR);
		vox_we = clearing || (pop && job.kind == JOB_WRITE);
		vox_waddr = clearing ? clr_q : job.vaddr;
		vox_wdata = clearing ? BLK_NULL : job.blk;
		p_addr = vox_addr(job_q.axis, job_q.s_lo, bi_q, bj_q);
		q_addr = vox_addr(job_q.axis, job_q.s_next[2:0], bi_q, bj_q);
		case (state_q)
			ST_WID_RD: rd_addr = {cj_q[2:0], ci_w[2:0]};
			ST_HGT_RD: rd_addr = {cj_h[2:0], ci_k[2:0]};
			default:   rd_addr = {cj_q[2:0], ci_q[2:0]};
		endcase
		push_go = (state_q == ST_PUSH) && (!hold_valid_q || out_free);
		fin_go = (state_q == ST_FIN) && out_free;
		load_out = (push_go && hold_valid_q) || fin_go;
		oob_blk = (job_q.axis == AXIS_Z) ? BLK_AIR : BLK_NULL;
		pblk = job_q.p_oob ? oob_blk : vox_p_q;
		qblk = job_q.q_oob ? oob_blk : vox_q_q;

		for (int b = 0; b < 64; b++) begin
			col = {1'b0, 3'(b)};
			row = {1'b0, 3'(b / 8)};
			rect[b] = col >= ci_q && col < ci_w && row >= cj_q && row < cj_h;
		end

		empty_quad = '0;
		empty_quad.last = 1'b1;
		last_quad = hold_q;
		last_quad.last = 1'b1;
		new_quad.has_quad = 1'b1;
		new_quad.last = 1'b0;
		new_quad.face_axis = job_q.axis;
		new_quad.facing_negative = (m_q[4:3] == NRM_MINUS);
		case (job_q.axis)
			AXIS_X: begin
				new_quad.pos_x = job_q.s_next;
				new_quad.pos_y = ci_q;
				new_quad.pos_z = cj_q;
			end
			AXIS_Y: begin
				new_quad.pos_x = cj_q;
				new_quad.pos_y = job_q.s_next;
				new_quad.pos_z = ci_q;
			end
			default: begin
				new_quad.pos_x = ci_q;
				new_quad.pos_y = cj_q;
				new_quad.pos_z = job_q.s_next;
			end
		endcase
		new_quad.span_first = w_q;
		new_quad.span_second = h_q;
		new_quad.face_block = m_q[2:0];
		new_quad.texture_index = texture_of(m_q[2:0], job_q.axis, m_q[4:3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= 9'd0;
			valid_s1 <= 1'b0;
			used_q <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_q <= clr_q + 9'd1;
			valid_s1 <= (state_q == ST_BUILD);
			if (pop && job.kind == JOB_SLICE)
				used_q <= '0;
			else if (push_go)
				used_q <= used_q | rect;
			if (push_go)
				hold_valid_q <= 1'b1;
			else if (fin_go)
				hold_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!quad_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		bi_q <= bi_d;
		bj_q <= bj_d;
		ci_q <= ci_d;
		cj_q <= cj_d;
		w_q <= w_d;
		h_q <= h_d;
		k_q <= k_d;
		m_q <= m_d;
		midx_s1 <= {bj_q, bi_q};
		rd_addr_q <= rd_addr;
		if (pop)
			job_q <= job;
		if (push_go)
			hold_q <= new_quad;
		if (push_go && hold_valid_q) begin
			out_q <= hold_q;
		end else if (fin_go) begin
			if (hold_valid_q)
				out_q <= last_quad;
			else
				out_q <= empty_quad;
		end
	end

	always_ff @(posedge clk) begin
		if (vox_we)
			vox_mem[vox_waddr] <= vox_wdata;
		vox_p_q <= vox_mem[p_addr];
		vox_q_q <= vox_mem[q_addr];
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			mask_mem[midx_s1] <= mark_of(pblk, qblk);
		rd_q <= mask_mem[rd_addr];
	end

	assign quad = out_q;
	assign quad_valid = out_valid_q;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_quad |-> out_q.last)
		else $error("empty slice result without last");

	a_width_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> ci_w <= job_q.len1 && w_q != 4'd0)
		else $error("rectangle width leaves the slice");

	a_height_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> cj_h <= job_q.len2 && h_q != 4'd0)
		else $error("rectangle height leaves the slice");

	a_used_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUILD && $past(state_q) == ST_IDLE |-> used_q == '0)
		else $error("merge marks not cleared at slice start");

	a_hold_form: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> hold_q.has_quad && !hold_q.last)
		else $error("held quad malformed");

endmodule
